>>> rtl/mtf_pkg.sv
// mtf_pkg: shared types and constants of the move-to-front list
// used by mtf_cell and move_to_front_list_core; no dependencies
package mtf_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KIND_W    = 2;
    localparam int KEY_IN_W  = 32;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_FIND  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef logic [KEY_WIDTH-1:0] t_key;

    typedef struct packed {
        logic add_ok;
        logic find;
        logic hit_any;
    } t_cell_ctl;

endpackage

>>> rtl/mtf_cell.sv
// mtf_cell: one list position, holds a key and shifts from its front neighbor
// depends on mtf_pkg
module mtf_cell
    import mtf_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_accept,
    input  t_key      i_key,
    input  t_key      i_prev_key,
    input  logic      i_occ,
    input  logic      i_hit_in,
    output logic      o_hit_out,
    output t_key      o_entry
);

    t_key r_entry;
    t_key n_entry;
    logic w_match;
    logic w_shift;

    assign w_match   = i_occ && i_ctl.find && (r_entry == i_key);
    assign o_hit_out = i_hit_in || w_match;
    // shift when adding, or when the first hit is at or behind this position
    assign w_shift   = i_ctl.add_ok || (i_ctl.find && i_ctl.hit_any && !i_hit_in);
    assign n_entry   = w_shift ? i_prev_key : r_entry;
    assign o_entry   = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

>>> rtl/move_to_front_list_core.sv
// move_to_front_list_core: self-adjusting move-to-front key list, top level
// depends on mtf_pkg and mtf_cell
//
//  channel | signals                          | direction
//  request | i_valid o_stall i_kind i_key     | in
//  result  | o_valid i_stall o_ok o_list_count| out
//
// one request per cycle while the result is not stalled; compare, first-hit chain
// and shift all happen in the row of cells in the cycle of acceptance, result registered
// the first-hit chain runs through all CAPACITY cells
// reset clears the count and the result valid; stored keys are not cleared
// a stalled result stalls requests only while it is still waiting
module move_to_front_list_core
    import mtf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [KEY_IN_W-1:0]  i_key,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_ok,
    output logic [CNT_OUT_W-1:0] o_list_count
);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_valid;
    logic                      r_ok;
    logic                      n_ok;
    logic                      w_accept;
    t_key                      w_key;
    t_cell_ctl                 w_ctl;
    logic [CAPACITY:0]         w_hit;
    logic [CAPACITY-1:0]       w_occ;
    t_key                      w_entry [CAPACITY];
    logic [CNT_W+CNT_OUT_W-1:0] w_count_ext;

    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_key    = i_key[KEY_WIDTH-1:0];

    assign w_ctl.add_ok  = (i_kind == KIND_ADD) && (r_count < CNT_W'(CAPACITY));
    assign w_ctl.find    = (i_kind == KIND_FIND);
    assign w_ctl.hit_any = w_hit[CAPACITY];
    assign w_hit[0]      = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_occ[g] = (CNT_W'(g) < r_count);
            mtf_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_accept   (w_accept),
                .i_key      (w_key),
                .i_prev_key ((g == 0) ? w_key : w_entry[(g == 0) ? 0 : g - 1]),
                .i_occ      (w_occ[g]),
                .i_hit_in   (w_hit[g]),
                .o_hit_out  (w_hit[g+1]),
                .o_entry    (w_entry[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        case (i_kind)
            KIND_ADD: begin
                if (w_ctl.add_ok) begin
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            KIND_FIND: begin
                n_ok = w_hit[CAPACITY];
            end
            KIND_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok <= n_ok;
        end
    end

    assign w_count_ext  = {{CNT_OUT_W{1'b0}}, r_count};
    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_list_count = w_count_ext[CNT_OUT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_kind == KIND_CLEAR) |=> (r_count == '0) && r_ok && r_valid)
        else $error("clear did not empty the list");

    a_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_ctl.add_ok |=> (r_count == $past(r_count) + CNT_W'(1))
            && (w_entry[0] == $past(w_key)))
        else $error("add did not place key at front");

    a_find_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_ctl.find && w_hit[CAPACITY] |=> (w_entry[0] == $past(w_key))
            && (r_count == $past(r_count)) && r_ok)
        else $error("find hit did not move key to front");

endmodule
